// ----- sv/wgm_pkg.sv -----
// wgm_pkg: shared constants, codes and types of the wildcard glob matcher
// used by wgm_cfg, wgm_cell and wildcard_glob_matcher; depends on nothing

package wgm_pkg;

  // pattern geometry
  localparam int PATTERN_BYTES = 16;
  localparam int NUM_POS       = PATTERN_BYTES + 1;
  localparam int LEN_W         = $clog2(PATTERN_BYTES + 1);
  localparam int REG_LEN_W     = 5;
  localparam int PAT_W         = 64;

  // apb port geometry
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 5;

  // pattern characters with a meaning
  localparam logic [7:0] CHAR_STAR  = 8'h2A;
  localparam logic [7:0] CHAR_QMARK = 8'h3F;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;

  // register indexes (byte address divided by 8)
  typedef enum logic [1:0] {
    REG_PAT_LOW  = 2'd0,
    REG_PAT_HIGH = 2'd1,
    REG_PAT_LEN  = 2'd2
  } reg_idx_t;

  // register contents handed to the datapath
  typedef struct packed {
    logic [PAT_W-1:0]     pat_low;
    logic [PAT_W-1:0]     pat_high;
    logic [REG_LEN_W-1:0] pat_len;
  } cfg_regs_t;

  // signals passed from one cell to the next
  typedef struct packed {
    logic cl;   // star closure carry of the current vector
    logic adv;  // position advance on this character
    logic ncl;  // star closure carry of the next vector
  } link_t;

  // per-item control broadcast to all cells
  typedef struct packed {
    logic take;
    logic eot;
  } step_t;

endpackage

// ----- sv/wgm_cfg.sv -----
// wgm_cfg: apb register file holding the glob pattern and its length
// depends on wgm_pkg

module wgm_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [wgm_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [wgm_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [wgm_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           wr_en,
  output wgm_pkg::cfg_regs_t             regs
);

  logic [wgm_pkg::PAT_W-1:0]     pat_low_r;
  logic [wgm_pkg::PAT_W-1:0]     pat_high_r;
  logic [wgm_pkg::REG_LEN_W-1:0] pat_len_r;
  wgm_pkg::reg_idx_t             idx;

  assign idx   = wgm_pkg::reg_idx_t'(paddr[wgm_pkg::CFG_ADDR_W-1:3]);
  assign wr_en = psel & penable & pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r  <= '0;
      pat_high_r <= '0;
      pat_len_r  <= '0;
    end else if (wr_en) begin
      unique case (idx)
        wgm_pkg::REG_PAT_LOW:  pat_low_r  <= pwdata[wgm_pkg::PAT_W-1:0];
        wgm_pkg::REG_PAT_HIGH: pat_high_r <= pwdata[wgm_pkg::PAT_W-1:0];
        wgm_pkg::REG_PAT_LEN:  pat_len_r  <= pwdata[wgm_pkg::REG_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      wgm_pkg::REG_PAT_LOW:  prdata = pat_low_r;
      wgm_pkg::REG_PAT_HIGH: prdata = pat_high_r;
      wgm_pkg::REG_PAT_LEN:
        prdata = {{(wgm_pkg::CFG_DATA_W-wgm_pkg::REG_LEN_W){1'b0}}, pat_len_r};
      default:               prdata = '0;
    endcase
  end

  assign regs = '{pat_low: pat_low_r, pat_high: pat_high_r, pat_len: pat_len_r};

endmodule

// ----- sv/wgm_cell.sv -----
// wgm_cell: one nfa position, holding its active bit and passing star
// closure and advance signals to the next position; depends on wgm_pkg

module wgm_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           is_head,   // position zero, active after re-arm
  input  logic           in_range,  // position index <= pattern length
  input  logic           has_byte,  // position index < pattern length
  input  logic [7:0]     pat_byte,
  input  logic [7:0]     chr,
  input  wgm_pkg::step_t step,
  input  wgm_pkg::link_t lk_in,
  output wgm_pkg::link_t lk_out,
  output logic           cur
);

  logic act_r;
  logic act_nxt;
  logic is_star;
  logic hit;
  logic nxt;
  logic closed;

  // current vector: stored bit plus closure from the left
  assign is_star = (pat_byte == wgm_pkg::CHAR_STAR);
  assign hit     = (pat_byte == wgm_pkg::CHAR_QMARK) | (pat_byte == chr);
  assign cur     = in_range & (act_r | lk_in.cl);

  // next vector for a text character, then its closure
  assign nxt    = (has_byte & cur & is_star) | lk_in.adv;
  assign closed = in_range & (nxt | lk_in.ncl);

  assign lk_out.cl  = has_byte & cur & is_star;
  assign lk_out.adv = has_byte & cur & ~is_star & hit;
  assign lk_out.ncl = has_byte & closed & is_star;

  // state update on each accepted item
  always_comb begin
    act_nxt = act_r;
    if (step.take) begin
      act_nxt = step.eot ? is_head : closed;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= is_head;
    end else begin
      act_r <= act_nxt;
    end
  end

endmodule

// ----- sv/wildcard_glob_matcher.sv -----
// wildcard_glob_matcher: top level, apb pattern registers, a row of nfa
// position cells and the result register; depends on wgm_pkg, wgm_cfg, wgm_cell

// Matches a text streamed one byte per item against a glob pattern of up to
// 16 bytes ('*' any run, '?' any one byte, others literal). The position
// cells update their active bits in one pass through the row, so a new
// item is accepted every cycle while the result register can be emptied.
// A tlast item closes the text, yields one matched flag and re-arms the
// matcher; character items yield nothing. The pattern "*.*" matches any
// text. Write the pattern registers while no text is in flight.

module wildcard_glob_matcher (
  input  logic                           clk,
  input  logic                           rst_n,
  // apb configuration port
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [wgm_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [wgm_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [wgm_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready,
  // text input
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [7:0] character
  input  logic                           in_tlast,   // end_of_text
  // match result
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [7:0]                     out_tdata   // [0] matched, [7:1] zero
);

  localparam int NP = wgm_pkg::NUM_POS;
  localparam int LW = wgm_pkg::LEN_W;

  wgm_pkg::cfg_regs_t  regs;
  logic                cfg_wr;
  logic [2*wgm_pkg::PAT_W-1:0] pat_w;
  logic [LW-1:0]       len;
  logic [7:0]          pat_byte [NP];
  wgm_pkg::link_t      lk [NP+1];
  logic [NP-1:0]       cur_vec;
  logic [NP-1:0]       in_range_vec;
  wgm_pkg::step_t      step;
  logic                accept;
  logic                dot_any;
  logic                match;
  logic                out_valid_r;
  logic                out_valid_nxt;
  logic                matched_r;
  logic                matched_nxt;

  assign cfg_pready = 1'b1;

  wgm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .wr_en   (cfg_wr),
    .regs    (regs)
  );

  // pattern bytes and saturated length
  assign pat_w = {regs.pat_high, regs.pat_low};
  assign len = (regs.pat_len > wgm_pkg::REG_LEN_W'(wgm_pkg::PATTERN_BYTES)) ?
               LW'(wgm_pkg::PATTERN_BYTES) : regs.pat_len[LW-1:0];

  always_comb begin
    for (int i = 0; i < NP - 1; i++) begin
      pat_byte[i] = pat_w[i*8 +: 8];
    end
    pat_byte[NP-1] = 8'h00;
  end

  // handshake and broadcast control
  assign in_tready = ~out_valid_r | out_tready;
  assign accept    = in_tvalid & in_tready;
  assign step      = '{take: accept, eot: in_tlast};

  // row of position cells
  assign lk[0] = '0;

  for (genvar g = 0; g < NP; g++) begin : g_cell
    assign in_range_vec[g] = (len >= LW'(g));
    wgm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .is_head  (g == 0),
      .in_range (in_range_vec[g]),
      .has_byte (len > LW'(g)),
      .pat_byte (pat_byte[g]),
      .chr      (in_tdata),
      .step     (step),
      .lk_in    (lk[g]),
      .lk_out   (lk[g+1]),
      .cur      (cur_vec[g])
    );
  end

  // match decision at end of text
  assign dot_any = (len == LW'(3)) && (pat_w[7:0] == wgm_pkg::CHAR_STAR) &&
                   (pat_w[15:8] == wgm_pkg::CHAR_DOT) &&
                   (pat_w[23:16] == wgm_pkg::CHAR_STAR);
  assign match   = dot_any | cur_vec[len];

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    matched_nxt   = matched_r;
    if (accept && in_tlast) begin
      out_valid_nxt = 1'b1;
      matched_nxt   = match;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    matched_r <= matched_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, matched_r};

`ifndef NO_ASSERTIONS
  // closing item re-arms to position zero only, unless the pattern opens with a star
  a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_tlast && !cfg_wr) |=> (cur_vec[0] && cur_vec[NP-1:1] == '0) ||
      (pat_byte[0] == wgm_pkg::CHAR_STAR))
    else $error("matcher not re-armed after end of text");

  // the last position never hands anything on
  a_tail: assert property (@(posedge clk) disable iff (!rst_n)
    lk[NP] == '0)
    else $error("carry out of last position");

  // no active position beyond the pattern length
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_vec & ~in_range_vec) == '0)
    else $error("active position beyond pattern length");

  // a result appears only after a closing item
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(accept && in_tlast))
    else $error("result without end of text");
`endif

endmodule
